// ----- sv/deformed_point_rigid_transform_unit_assert.svh -----
// assertion macros used by the pipe control rtl
`ifndef DEFORMED_POINT_RIGID_TRANSFORM_UNIT_ASSERT_SVH
`define DEFORMED_POINT_RIGID_TRANSFORM_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define DPRT_ASSERT(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("dprt check failed");
`define DPRT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dprt check failed");
`else
`define DPRT_ASSERT(label, clk, rst, expr)
`define DPRT_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ----- sv/dprt_pkg.sv -----
package dprt_pkg;

   // field widths
   localparam int COORD_W   = 18;
   localparam int COEF_FRAC = 16;
   localparam int ROT_W     = COEF_FRAC + 2;
   localparam int ROT_ROW_W = 3 * ROT_W;
   localparam int TR_W      = 21;
   localparam int TRANS_W   = 3 * TR_W;
   localparam int OUT_W     = 22;
   localparam int SCALE_W   = 24;
   localparam int NPAR_W    = 32;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = TRANS_W;

   // stream word widths, padded to bytes
   localparam int REQ_DATA_W = ((3 * COORD_W + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((3 * OUT_W + 7) / 8) * 8;

   // y correction datapath
   localparam int D_W        = COORD_W + 1;
   localparam int DD_W       = 2 * D_W;
   localparam int SPLIT      = D_W;
   localparam int HI_W       = DD_W - SPLIT;
   localparam int LO_PW      = SPLIT + 1 + NPAR_W;
   localparam int HI_PW      = HI_W + NPAR_W;
   localparam int PROD_W     = DD_W + NPAR_W;
   localparam int S_W        = D_W + SCALE_W;
   localparam int NP_SHIFT   = 16;
   localparam int N_W        = PROD_W - NP_SHIFT;
   localparam int SUM_W      = N_W + 2;
   localparam int CORR_SHIFT = 24;
   localparam int CORR_W     = SUM_W - CORR_SHIFT;
   localparam int YD_W       = CORR_W + 1;

   // rotation datapath
   localparam int PR_W  = ROT_W + YD_W;
   localparam int ACC_W = PR_W + 3;
   localparam int R_W   = ACC_W - COEF_FRAC;

   // pipeline
   localparam int YC_STAGES  = 5;
   localparam int ROT_STAGES = 3;
   localparam int NUM_STAGES = YC_STAGES + ROT_STAGES;

   localparam logic [ROT_ROW_W-1:0] ROT_ROW0_RST = ROT_ROW_W'(1) << COEF_FRAC;
   localparam logic [ROT_ROW_W-1:0] ROT_ROW1_RST = ROT_ROW_W'(1) << (COEF_FRAC + ROT_W);
   localparam logic [ROT_ROW_W-1:0] ROT_ROW2_RST =
      ROT_ROW_W'(1) << (COEF_FRAC + 2 * ROT_W);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ORIGIN_X    = 3'd0,
      CSR_ORIGIN_Y    = 3'd1,
      CSR_SCALE_COEF  = 3'd2,
      CSR_NONPAR_COEF = 3'd3,
      CSR_ROT_ROW0    = 3'd4,
      CSR_ROT_ROW1    = 3'd5,
      CSR_ROT_ROW2    = 3'd6,
      CSR_TRANSLATION = 3'd7
   } csr_index_type;

   typedef logic [NUM_STAGES-1:0] stage_vec_type;

   typedef struct packed {
      stage_vec_type adv;
      stage_vec_type valid;
   } pipe_ctrl_type;

   typedef struct packed {
      logic signed [COORD_W-1:0]  origin_x;
      logic signed [COORD_W-1:0]  origin_y;
      logic signed [SCALE_W-1:0]  scale_coef;
      logic signed [NPAR_W-1:0]   nonpar_coef;
      logic [2:0][ROT_ROW_W-1:0]  rot;
      logic [TRANS_W-1:0]         translation;
   } cfg_type;

endpackage

// ----- sv/dprt_csr.sv -----
module dprt_csr
   import dprt_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output cfg_type               cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_ORIGIN_X:    cfg_in.origin_x    = $signed(csr_wdata[COORD_W-1:0]);
            CSR_ORIGIN_Y:    cfg_in.origin_y    = $signed(csr_wdata[COORD_W-1:0]);
            CSR_SCALE_COEF:  cfg_in.scale_coef  = $signed(csr_wdata[SCALE_W-1:0]);
            CSR_NONPAR_COEF: cfg_in.nonpar_coef = $signed(csr_wdata[NPAR_W-1:0]);
            CSR_ROT_ROW0:    cfg_in.rot[0]      = csr_wdata[ROT_ROW_W-1:0];
            CSR_ROT_ROW1:    cfg_in.rot[1]      = csr_wdata[ROT_ROW_W-1:0];
            CSR_ROT_ROW2:    cfg_in.rot[2]      = csr_wdata[ROT_ROW_W-1:0];
            CSR_TRANSLATION: cfg_in.translation = csr_wdata[TRANS_W-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.origin_x    <= '0;
         cfg_ff.origin_y    <= '0;
         cfg_ff.scale_coef  <= '0;
         cfg_ff.nonpar_coef <= '0;
         cfg_ff.rot[0]      <= ROT_ROW0_RST;
         cfg_ff.rot[1]      <= ROT_ROW1_RST;
         cfg_ff.rot[2]      <= ROT_ROW2_RST;
         cfg_ff.translation <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- sv/dprt_pipe.sv -----
`include "deformed_point_rigid_transform_unit_assert.svh"
module dprt_pipe
   import dprt_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   input  logic          out_ready,
   output pipe_ctrl_type ctrl
);

   stage_vec_type valid_ff;
   stage_vec_type valid_in;
   stage_vec_type adv;
   stage_vec_type held;
   logic          word_enter;
   logic          word_leave;
   int            words_now;
   int            words_next;

   // a stage loads when it is empty or its word moves on
   always_comb begin
      adv[NUM_STAGES-1] = !valid_ff[NUM_STAGES-1] || out_ready;
      for (int k = NUM_STAGES - 2; k >= 0; k--) begin
         adv[k] = !valid_ff[k] || adv[k+1];
      end
   end

   always_comb begin
      valid_in[0] = adv[0] ? in_valid : valid_ff[0];
      for (int k = 1; k < NUM_STAGES; k++) begin
         valid_in[k] = adv[k] ? valid_ff[k-1] : valid_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign word_enter = in_valid && adv[0];
   assign word_leave = valid_ff[NUM_STAGES-1] && out_ready;
   assign held       = valid_ff & ~adv;
   assign words_now  = $countones(valid_ff);
   assign words_next = words_now + int'(word_enter) - int'(word_leave);
   assign ctrl.adv   = adv;
   assign ctrl.valid = valid_ff;

   // words in flight change only by what enters and what leaves
   `DPRT_ASSERT_NEXT(a_word_count, clock, reset, 1'b1, words_now == $past(words_next))
   // a held stage keeps its word
   `DPRT_ASSERT_NEXT(a_stage_hold, clock, reset, 1'b1, (valid_ff & $past(held)) == $past(held))
   // a full stalled pipe takes nothing in
   `DPRT_ASSERT(a_full_stall, clock, reset, !((&valid_ff) && !out_ready && adv[0]))

endmodule

// ----- sv/dprt_ycorr.sv -----
module dprt_ycorr
   import dprt_pkg::*;
(
   input  logic                      clock,
   input  pipe_ctrl_type             ctrl,
   input  cfg_type                   cfg,
   input  logic signed [COORD_W-1:0] local_x,
   input  logic signed [COORD_W-1:0] local_y,
   input  logic signed [COORD_W-1:0] local_z,
   output logic signed [COORD_W-1:0] x_out,
   output logic signed [COORD_W-1:0] z_out,
   output logic signed [YD_W-1:0]    yd_out
);

   localparam logic signed [SUM_W-1:0] CORR_ROUND = SUM_W'(2 ** (CORR_SHIFT - 1));

   // coordinate taps, one per stage for x and z; y taps stop at stage 3
   logic signed [COORD_W-1:0] x_ff [YC_STAGES];
   logic signed [COORD_W-1:0] y_ff [YC_STAGES-1];
   logic signed [COORD_W-1:0] z_ff [YC_STAGES];

   logic signed [D_W-1:0]    dx_ff, dx_in, dy_ff, dy_in;
   logic signed [DD_W-1:0]   dd_ff, dd_in;
   logic signed [S_W-1:0]    s2_ff, s2_in, s3_ff, s4_ff;
   logic signed [LO_PW-1:0]  lo_ff, lo_in;
   logic signed [HI_PW-1:0]  hi_ff, hi_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [N_W-1:0]    nterm;
   logic signed [SUM_W-1:0]  sum;
   logic signed [CORR_W-1:0] corr;
   logic signed [YD_W-1:0]   yd_ff, yd_in;

   // stage 0: offsets from the deformation origin
   assign dx_in = D_W'(local_x) - D_W'(cfg.origin_x);
   assign dy_in = D_W'(local_y) - D_W'(cfg.origin_y);
   // stage 1: dx*dy and the scale term
   assign dd_in = DD_W'(dx_ff) * DD_W'(dy_ff);
   assign s2_in = S_W'(dy_ff) * S_W'(cfg.scale_coef);
   // stage 2: dx*dy*coef split into two partial products
   assign lo_in = LO_PW'($signed({1'b0, dd_ff[SPLIT-1:0]})) * LO_PW'(cfg.nonpar_coef);
   assign hi_in = HI_PW'($signed(dd_ff[DD_W-1:SPLIT])) * HI_PW'(cfg.nonpar_coef);
   // stage 3: join partial products
   assign prod_in = $signed({hi_ff, {SPLIT{1'b0}}}) + PROD_W'(lo_ff);
   // stage 4: floor to 24 fraction bits, round half up, add to y
   assign nterm = $signed(prod_ff[PROD_W-1:NP_SHIFT]);
   assign sum   = SUM_W'(s4_ff) + SUM_W'(nterm) + CORR_ROUND;
   assign corr  = $signed(sum[SUM_W-1:CORR_SHIFT]);
   assign yd_in = YD_W'(y_ff[YC_STAGES-2]) + YD_W'(corr);

   always_ff @(posedge clock) begin
      if (ctrl.adv[0]) begin
         x_ff[0] <= local_x;
         y_ff[0] <= local_y;
         z_ff[0] <= local_z;
         dx_ff   <= dx_in;
         dy_ff   <= dy_in;
      end
      for (int k = 1; k < YC_STAGES; k++) begin
         if (ctrl.adv[k]) begin
            x_ff[k] <= x_ff[k-1];
            z_ff[k] <= z_ff[k-1];
         end
      end
      for (int k = 1; k < YC_STAGES - 1; k++) begin
         if (ctrl.adv[k]) begin
            y_ff[k] <= y_ff[k-1];
         end
      end
      if (ctrl.adv[1]) begin
         dd_ff <= dd_in;
         s2_ff <= s2_in;
      end
      if (ctrl.adv[2]) begin
         lo_ff <= lo_in;
         hi_ff <= hi_in;
         s3_ff <= s2_ff;
      end
      if (ctrl.adv[3]) begin
         prod_ff <= prod_in;
         s4_ff   <= s3_ff;
      end
      if (ctrl.adv[4]) begin
         yd_ff <= yd_in;
      end
   end

   assign x_out  = x_ff[YC_STAGES-1];
   assign z_out  = z_ff[YC_STAGES-1];
   assign yd_out = yd_ff;

endmodule

// ----- sv/dprt_rotate.sv -----
module dprt_rotate
   import dprt_pkg::*;
(
   input  logic                      clock,
   input  pipe_ctrl_type             ctrl,
   input  cfg_type                   cfg,
   input  logic signed [COORD_W-1:0] x_in,
   input  logic signed [YD_W-1:0]    yd_in,
   input  logic signed [COORD_W-1:0] z_in,
   output logic signed [OUT_W-1:0]   out_x,
   output logic signed [OUT_W-1:0]   out_y,
   output logic signed [OUT_W-1:0]   out_z,
   output logic                      saturated
);

   localparam int S_MUL = YC_STAGES;
   localparam int S_ACC = YC_STAGES + 1;
   localparam int S_CLP = YC_STAGES + 2;
   localparam logic signed [ACC_W-1:0] ACC_ROUND = ACC_W'(2 ** (COEF_FRAC - 1));
   localparam logic signed [R_W-1:0] OUT_HI =
      R_W'($signed({1'b0, {(OUT_W - 1){1'b1}}}));
   localparam logic signed [R_W-1:0] OUT_LO =
      R_W'($signed({1'b1, {(OUT_W - 1){1'b0}}}));

   logic signed [YD_W-1:0]  pv [3];
   logic signed [PR_W-1:0]  prod_ff [3][3];
   logic signed [PR_W-1:0]  prod_in [3][3];
   logic signed [ACC_W-1:0] acc_ff [3];
   logic signed [ACC_W-1:0] acc_in [3];
   logic signed [R_W-1:0]   r [3];
   logic signed [OUT_W-1:0] out_ff [3];
   logic signed [OUT_W-1:0] out_in [3];
   logic                    sat_ff;
   logic                    sat_in;

   assign pv[0] = YD_W'(x_in);
   assign pv[1] = yd_in;
   assign pv[2] = YD_W'(z_in);

   // nine coefficient products in parallel
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            prod_in[i][j] = PR_W'($signed(cfg.rot[i][ROT_W*j +: ROT_W])) * PR_W'(pv[j]);
         end
      end
   end

   // row sums with translation and rounding offset
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         acc_in[i] = ACC_W'(prod_ff[i][0]) + ACC_W'(prod_ff[i][1]) + ACC_W'(prod_ff[i][2])
                   + ACC_W'($signed({cfg.translation[TR_W*i +: TR_W], {COEF_FRAC{1'b0}}}))
                   + ACC_ROUND;
      end
   end

   // drop fraction bits and clip
   always_comb begin
      sat_in = 1'b0;
      for (int i = 0; i < 3; i++) begin
         r[i] = $signed(acc_ff[i][ACC_W-1:COEF_FRAC]);
         if (r[i] > OUT_HI) begin
            out_in[i] = OUT_HI[OUT_W-1:0];
            sat_in    = 1'b1;
         end else if (r[i] < OUT_LO) begin
            out_in[i] = OUT_LO[OUT_W-1:0];
            sat_in    = 1'b1;
         end else begin
            out_in[i] = r[i][OUT_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.adv[S_MUL]) begin
         prod_ff <= prod_in;
      end
      if (ctrl.adv[S_ACC]) begin
         acc_ff <= acc_in;
      end
      if (ctrl.adv[S_CLP]) begin
         out_ff <= out_in;
         sat_ff <= sat_in;
      end
   end

   assign out_x     = out_ff[0];
   assign out_y     = out_ff[1];
   assign out_z     = out_ff[2];
   assign saturated = sat_ff;

endmodule

// ----- sv/deformed_point_rigid_transform_unit.sv -----
// channel   dir   word                                       handshake
// req       in    tdata: local_x, local_y, local_z, pad       tvalid / tready
// rsp       out   tdata: out_x, out_y, out_z, pad             tvalid / tready
//                 tuser: saturated
// csr       in    index 0..7, data up to 63 bits              csr_wr_en, no wait
//
// eight register stages: one word in and one word out per cycle when both sides flow
// the depth from req acceptance to rsp_tvalid is set by the multiplier chain
//   (dx*dy, times the non-parallelism coefficient, then the rotation products)
// each stage holds its word while the next stage holds its own, empty stages fill behind a stall
// synchronous reset empties the pipe and loads identity rotation, zero origin and offsets
module deformed_point_rigid_transform_unit
   import dprt_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // request stream
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // local_x, local_y, local_z, zero pad
   // result stream
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // out_x, out_y, out_z, zero pad
   output logic                  rsp_tuser,   // saturated
   // register writes
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type                   cfg;
   pipe_ctrl_type             ctrl;
   logic signed [COORD_W-1:0] local_x, local_y, local_z;
   logic signed [COORD_W-1:0] def_x, def_z;
   logic signed [YD_W-1:0]    def_y;
   logic signed [OUT_W-1:0]   out_x, out_y, out_z;
   logic                      saturated;

   // unpack the request word, x in the lowest bits
   assign local_x = $signed(req_tdata[COORD_W-1:0]);
   assign local_y = $signed(req_tdata[2*COORD_W-1:COORD_W]);
   assign local_z = $signed(req_tdata[3*COORD_W-1:2*COORD_W]);

   // configuration registers
   dprt_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // stage valid bits and per-stage advance
   dprt_pipe u_pipe (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .out_ready (rsp_tready),
      .ctrl      (ctrl)
   );

   // stages 0..4: offsets, y scale and non-parallelism correction
   dprt_ycorr u_ycorr (
      .clock   (clock),
      .ctrl    (ctrl),
      .cfg     (cfg),
      .local_x (local_x),
      .local_y (local_y),
      .local_z (local_z),
      .x_out   (def_x),
      .z_out   (def_z),
      .yd_out  (def_y)
   );

   // stages 5..7: rotation products, row sums plus translation, round and clip
   dprt_rotate u_rotate (
      .clock     (clock),
      .ctrl      (ctrl),
      .cfg       (cfg),
      .x_in      (def_x),
      .yd_in     (def_y),
      .z_in      (def_z),
      .out_x     (out_x),
      .out_y     (out_y),
      .out_z     (out_z),
      .saturated (saturated)
   );

   // a word enters whenever the first stage is free or moving on
   assign req_tready = ctrl.adv[0];
   assign rsp_tvalid = ctrl.valid[NUM_STAGES-1];
   assign rsp_tdata  = RSP_DATA_W'({out_z, out_y, out_x});
   assign rsp_tuser  = saturated;

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps

module tb;
   import dprt_pkg::*;

   // predictor arithmetic runs wide enough that nothing wraps
   typedef logic signed [127:0] wide_type;

   // one result word, unpacked from rsp_tdata and rsp_tuser
   typedef struct packed {
      logic signed [OUT_W-1:0] x;
      logic signed [OUT_W-1:0] y;
      logic signed [OUT_W-1:0] z;
      logic                    sat;
   } point_res_type;

   // answer typed into the directed table, or left to the predictor
   typedef struct packed {
      logic          given;
      point_res_type res;
   } answer_type;

   // one row of the directed table: either a register write or a point
   typedef struct packed {
      logic                    is_cfg;
      csr_index_type           idx;
      logic [CSR_DATA_W-1:0]   val;
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] z;
      answer_type              ans;
   } stim_row_type;

   // how a register set is drawn for a random phase
   typedef enum int {
      CFG_GENTLE,
      CFG_WILD,
      CFG_EXTREME,
      CFG_MIXED
   } cfg_style_type;

   localparam int       NPAR_DROP   = 16;
   localparam int       CORR_DROP   = 24;
   localparam wide_type NPAR_LIM    = wide_type'(1) <<< 58;
   localparam wide_type YD_LIM      = wide_type'(1) <<< 35;
   localparam wide_type CORR_HALF   = wide_type'(1) <<< (CORR_DROP - 1);
   localparam wide_type ROUND_HALF  = wide_type'(1) <<< (COEF_FRAC - 1);
   localparam wide_type OUT_HI      = (wide_type'(1) <<< (OUT_W - 1)) - 1;
   localparam wide_type OUT_LO      = -(wide_type'(1) <<< (OUT_W - 1));
   localparam int       QUIET_LIMIT = 2000;
   localparam int       PHASES      = 8;
   localparam int       PHASE_WORDS = 80;

   logic                  clock;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;   // local_x, local_y, local_z, zero pad
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;         // out_x, out_y, out_z, zero pad
   logic                  rsp_tuser;         // saturated
   logic                  csr_wr_en  = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index  = '0;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;

   // our own copy of the register file, updated as writes go out
   cfg_type       shadow_cfg;
   // expected words in acceptance order, and answers queued by the sender
   point_res_type expected_points[$];
   answer_type    table_answers[$];
   int            fail_count   = 0;
   int            quiet_cycles = 0;
   // sender burst shaping
   int            burst_left   = 0;
   int            gap_len      = 0;
   // receiver stall pattern
   int            stall_mode   = 0;
   int            stall_left   = 0;

   deformed_point_rigid_transform_unit uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // deform y by the scale and non-parallelism terms, then rotate, translate and clip
   function automatic point_res_type transform_point(logic signed [COORD_W-1:0] lx,
                                                     logic signed [COORD_W-1:0] ly,
                                                     logic signed [COORD_W-1:0] lz);
      wide_type      x, y, z, dx, dy, scale_term, npar_term, yd, acc, r;
      wide_type      p [3];
      logic signed [OUT_W-1:0] o [3];
      logic          sat;
      point_res_type res;
      x = lx;
      y = ly;
      z = lz;
      dx = x - $signed(shadow_cfg.origin_x);
      dy = y - $signed(shadow_cfg.origin_y);
      scale_term = dy * $signed(shadow_cfg.scale_coef);
      // floor of the product with 40 fractional bits down to 24
      npar_term = (dx * dy * $signed(shadow_cfg.nonpar_coef)) >>> NPAR_DROP;
      if (npar_term > NPAR_LIM) npar_term = NPAR_LIM;
      if (npar_term < -NPAR_LIM) npar_term = -NPAR_LIM;
      // correction rounds half up
      yd = y + ((scale_term + npar_term + CORR_HALF) >>> CORR_DROP);
      if (yd > YD_LIM - 1) yd = YD_LIM - 1;
      if (yd < -YD_LIM) yd = -YD_LIM;
      p[0] = x;
      p[1] = yd;
      p[2] = z;
      sat = 1'b0;
      for (int i = 0; i < 3; i++) begin
         acc = $signed(shadow_cfg.translation[TR_W*i +: TR_W]) <<< COEF_FRAC;
         for (int j = 0; j < 3; j++)
            acc = acc + $signed(shadow_cfg.rot[i][ROT_W*j +: ROT_W]) * p[j];
         r = (acc + ROUND_HALF) >>> COEF_FRAC;
         if (r > OUT_HI) begin
            r = OUT_HI;
            sat = 1'b1;
         end else if (r < OUT_LO) begin
            r = OUT_LO;
            sat = 1'b1;
         end
         o[i] = r[OUT_W-1:0];
      end
      res.x = o[0];
      res.y = o[1];
      res.z = o[2];
      res.sat = sat;
      return res;
   endfunction

   function automatic void note_failure(string msg);
      fail_count++;
      if (fail_count <= 10) $display("%s", msg);
   endfunction

   function automatic stim_row_type cfg_row(csr_index_type idx, logic [CSR_DATA_W-1:0] val);
      stim_row_type r;
      r = '0;
      r.is_cfg = 1'b1;
      r.idx = idx;
      r.val = val;
      return r;
   endfunction

   function automatic stim_row_type point_row(int x, int y, int z);
      stim_row_type r;
      r = '0;
      r.x = COORD_W'(x);
      r.y = COORD_W'(y);
      r.z = COORD_W'(z);
      return r;
   endfunction

   function automatic stim_row_type typed_row(int x, int y, int z,
                                              int ex, int ey, int ez, bit es);
      stim_row_type r;
      r = point_row(x, y, z);
      r.ans.given = 1'b1;
      r.ans.res.x = OUT_W'(ex);
      r.ans.res.y = OUT_W'(ey);
      r.ans.res.z = OUT_W'(ez);
      r.ans.res.sat = es;
      return r;
   endfunction

   // register value for a random phase; bits above the register width stay as junk
   function automatic logic [CSR_DATA_W-1:0] draw_register(csr_index_type idx,
                                                           cfg_style_type style);
      logic [CSR_DATA_W-1:0] v, mask, fld;
      int            fw, nf, lim;
      cfg_style_type s;
      v = CSR_DATA_W'({$urandom, $urandom});
      s = style;
      if (s == CFG_MIXED) s = cfg_style_type'($urandom_range(0, 2));
      case (idx) inside
         CSR_ORIGIN_X, CSR_ORIGIN_Y: begin
            fw = COORD_W; nf = 1; lim = 131072;
         end
         CSR_SCALE_COEF: begin
            fw = SCALE_W; nf = 1; lim = 1 << 20;
         end
         CSR_NONPAR_COEF: begin
            fw = NPAR_W; nf = 1; lim = 1024;
         end
         CSR_TRANSLATION: begin
            fw = TR_W; nf = 3; lim = 1 << 17;
         end
         default: begin
            fw = ROT_W; nf = 3; lim = 1 << COEF_FRAC;
         end
      endcase
      if (s == CFG_WILD) return v;
      mask = (CSR_DATA_W'(1) << fw) - 1;
      for (int k = 0; k < nf; k++) begin
         if (s == CFG_GENTLE) begin
            fld = CSR_DATA_W'($urandom_range(0, 2 * lim) - lim);
         end else begin
            case ($urandom_range(0, 4))
               0:       fld = '0;
               1:       fld = mask >> 1;
               2:       fld = (mask >> 1) + 1;
               3:       fld = mask;
               default: fld = CSR_DATA_W'(1) << (fw - 2);
            endcase
         end
         v = (v & ~(mask << (k * fw))) | ((fld & mask) << (k * fw));
      end
      return v;
   endfunction

   // mostly full-range coordinates, some near the deformation origin, some extremes
   function automatic logic signed [COORD_W-1:0] draw_coord(
         logic signed [COORD_W-1:0] centre);
      case ($urandom_range(0, 19)) inside
         [0:1]:   return $urandom_range(0, 1) ? {1'b0, {(COORD_W-1){1'b1}}}
                                              : {1'b1, {(COORD_W-1){1'b0}}};
         [2:6]:   return centre + COORD_W'($urandom_range(0, 512) - 256);
         default: return COORD_W'($urandom);
      endcase
   endfunction

   // register write, then the enable is dropped again before returning
   task automatic write_register(csr_index_type idx, logic [CSR_DATA_W-1:0] val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_ORIGIN_X:    shadow_cfg.origin_x    = val[COORD_W-1:0];
         CSR_ORIGIN_Y:    shadow_cfg.origin_y    = val[COORD_W-1:0];
         CSR_SCALE_COEF:  shadow_cfg.scale_coef  = val[SCALE_W-1:0];
         CSR_NONPAR_COEF: shadow_cfg.nonpar_coef = val[NPAR_W-1:0];
         CSR_ROT_ROW0:    shadow_cfg.rot[0]      = val[ROT_ROW_W-1:0];
         CSR_ROT_ROW1:    shadow_cfg.rot[1]      = val[ROT_ROW_W-1:0];
         CSR_ROT_ROW2:    shadow_cfg.rot[2]      = val[ROT_ROW_W-1:0];
         CSR_TRANSLATION: shadow_cfg.translation = val[TRANS_W-1:0];
      endcase
      @(posedge clock);
      csr_wr_en <= 1'b0;
      csr_wdata <= CSR_DATA_W'({$urandom, $urandom});
      @(posedge clock);
   endtask

   // caller has dropped req_tvalid; the first edge lets the last acceptance land
   task automatic wait_for_results();
      @(posedge clock);
      while (expected_points.size() != 0) @(posedge clock);
   endtask

   // offer one word, hold it until accepted, then maybe close the burst with a gap
   task automatic send_point(logic signed [COORD_W-1:0] x, logic signed [COORD_W-1:0] y,
                             logic signed [COORD_W-1:0] z, answer_type ans);
      table_answers.push_back(ans);
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_DATA_W'({z, y, x});
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      burst_left--;
      if (burst_left <= 0) begin
         burst_left = $urandom_range(1, 24);
         // a quarter of the bursts run straight on into the next
         gap_len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
         if (gap_len > 0) begin
            req_tvalid <= 1'b0;
            req_tdata  <= REQ_DATA_W'({$urandom, $urandom});
            repeat (gap_len) @(posedge clock);
         end
      end
   endtask

   // receiver: stretches of always-ready, coin-toss, mostly-stalled and fully stalled
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode <= $urandom_range(0, 3);
         stall_left <= $urandom_range(4, 40);
      end else begin
         stall_left <= stall_left - 1;
      end
      case (stall_mode)
         0:       rsp_tready <= 1'b1;
         1:       rsp_tready <= 1'($urandom_range(0, 1));
         2:       rsp_tready <= ($urandom_range(0, 5) == 0);
         default: rsp_tready <= 1'b0;
      endcase
   end

   // prediction on request acceptance, comparison on result acceptance, same edge
   always @(posedge clock) begin
      answer_type    ans;
      point_res_type want;
      point_res_type got;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            ans = table_answers.pop_front();
            expected_points.push_back(ans.given ? ans.res :
               transform_point(req_tdata[COORD_W-1:0], req_tdata[2*COORD_W-1:COORD_W],
                               req_tdata[3*COORD_W-1:2*COORD_W]));
         end
         if (rsp_tvalid && rsp_tready) begin
            got.x   = rsp_tdata[OUT_W-1:0];
            got.y   = rsp_tdata[2*OUT_W-1:OUT_W];
            got.z   = rsp_tdata[3*OUT_W-1:2*OUT_W];
            got.sat = rsp_tuser;
            if (expected_points.size() == 0) begin
               note_failure($sformatf("unexpected word: x=%0d y=%0d z=%0d sat=%0b",
                                      got.x, got.y, got.z, got.sat));
            end else begin
               want = expected_points.pop_front();
               if (got.x !== want.x || got.y !== want.y || got.z !== want.z ||
                   got.sat !== want.sat)
                  note_failure($sformatf(
                     "mismatch: exp x=%0d y=%0d z=%0d sat=%0b got x=%0d y=%0d z=%0d sat=%0b",
                     want.x, want.y, want.z, want.sat, got.x, got.y, got.z, got.sat));
            end
         end
      end
   end

   // watchdog: too long with no word moving on either side
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("tb NOT OK");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      stim_row_type  directed_rows[$];
      stim_row_type  row;
      cfg_style_type style;

      // register file as it comes out of reset: identity rotation, zeros elsewhere
      shadow_cfg        = '0;
      shadow_cfg.rot[0] = ROT_ROW0_RST;
      shadow_cfg.rot[1] = ROT_ROW1_RST;
      shadow_cfg.rot[2] = ROT_ROW2_RST;

      // reset state passes points straight through
      directed_rows.push_back(typed_row(0, 0, 0, 0, 0, 0, 0));
      directed_rows.push_back(typed_row(131071, 131071, 131071, 131071, 131071, 131071, 0));
      directed_rows.push_back(typed_row(-131072, -131072, -131072,
                                        -131072, -131072, -131072, 0));
      directed_rows.push_back(typed_row(1, -1, -131072, 1, -1, -131072, 0));
      directed_rows.push_back(typed_row(-1, 0, 131071, -1, 0, 131071, 0));
      // translation extremes alone just add on
      directed_rows.push_back(cfg_row(CSR_TRANSLATION,
                                      {21'h000000, 21'h0fffff, 21'h100000}));
      directed_rows.push_back(typed_row(-131072, 131071, 5, -1179648, 1179646, 5, 0));
      // extreme coefficients; origins carry junk above their width
      directed_rows.push_back(cfg_row(CSR_ROT_ROW0, {3{18'h1ffff}}));
      directed_rows.push_back(cfg_row(CSR_ROT_ROW1, {3{18'h20000}}));
      directed_rows.push_back(cfg_row(CSR_ROT_ROW2, {18'h10000, 18'h30000, 18'h00001}));
      directed_rows.push_back(cfg_row(CSR_ORIGIN_X, 63'h7fff_ffff_fffe_0000));
      directed_rows.push_back(cfg_row(CSR_ORIGIN_Y, 63'h2aaa_aaaa_aaa9_ffff));
      directed_rows.push_back(cfg_row(CSR_SCALE_COEF, 63'h5a5a_5a5a_5a7f_ffff));
      directed_rows.push_back(cfg_row(CSR_NONPAR_COEF, 63'h7fff_ffff_8000_0000));
      directed_rows.push_back(point_row(131071, -131072, 0));
      directed_rows.push_back(point_row(-131072, 131071, 131071));
      directed_rows.push_back(point_row(131071, 131071, -131072));
      directed_rows.push_back(point_row(0, 0, 0));
      // opposite signs on the y correction terms, largest product of offsets
      directed_rows.push_back(cfg_row(CSR_ORIGIN_Y, 63'h0000_0000_0002_0000));
      directed_rows.push_back(cfg_row(CSR_SCALE_COEF, 63'h0000_0000_0080_0000));
      directed_rows.push_back(cfg_row(CSR_NONPAR_COEF, 63'h0000_0000_7fff_ffff));
      directed_rows.push_back(cfg_row(CSR_TRANSLATION, {3{21'h0fffff}}));
      directed_rows.push_back(point_row(131071, 131071, 131071));
      directed_rows.push_back(point_row(-131072, -131072, -131072));
      directed_rows.push_back(point_row(12345, -54321, 777));
      // back to the reset register set
      directed_rows.push_back(cfg_row(CSR_ORIGIN_X, '0));
      directed_rows.push_back(cfg_row(CSR_ORIGIN_Y, '0));
      directed_rows.push_back(cfg_row(CSR_SCALE_COEF, '0));
      directed_rows.push_back(cfg_row(CSR_NONPAR_COEF, '0));
      directed_rows.push_back(cfg_row(CSR_ROT_ROW0, CSR_DATA_W'(ROT_ROW0_RST)));
      directed_rows.push_back(cfg_row(CSR_ROT_ROW1, CSR_DATA_W'(ROT_ROW1_RST)));
      directed_rows.push_back(cfg_row(CSR_ROT_ROW2, CSR_DATA_W'(ROT_ROW2_RST)));
      directed_rows.push_back(cfg_row(CSR_TRANSLATION, '0));
      directed_rows.push_back(typed_row(100, -100, 100, 100, -100, 100, 0));

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed table: register rows only once the pipe has emptied
      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         if (row.is_cfg) begin
            req_tvalid <= 1'b0;
            wait_for_results();
            write_register(row.idx, row.val);
         end else begin
            send_point(row.x, row.y, row.z, row.ans);
         end
      end

      // random phases, each on a fresh register set drawn in its own style
      for (int ph = 0; ph < PHASES; ph++) begin
         req_tvalid <= 1'b0;
         wait_for_results();
         style = (ph < 4) ? cfg_style_type'(ph) : cfg_style_type'($urandom_range(0, 3));
         for (int k = 0; k < 8; k++)
            write_register(csr_index_type'(k), draw_register(csr_index_type'(k), style));
         for (int n = 0; n < PHASE_WORDS; n++) begin
            // mid-phase hold-off until every outstanding word has come back
            if (ph == 2 && n == PHASE_WORDS / 2) begin
               req_tvalid <= 1'b0;
               wait_for_results();
            end
            send_point(draw_coord(shadow_cfg.origin_x), draw_coord(shadow_cfg.origin_y),
                       draw_coord('0), '0);
         end
      end

      // drain, then a tail long enough for any stray word to show up
      req_tvalid <= 1'b0;
      wait_for_results();
      repeat (NUM_STAGES + 12) @(posedge clock);
      if (fail_count == 0 && expected_points.size() == 0)
         $display("tb OK");
      else
         $display("tb NOT OK");
      $finish;
   end

endmodule
